// File: rtl/bb3_pkg.sv
// Shared types and constants of the 3x3 edge-normalized box blur.
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

	// Widths fixed by the pixel and result formats.
	localparam int CH_W       = 16;
	localparam int CFG_W      = 11;
	localparam int POS_OUT_W  = 10;
	localparam int SUM_W      = 20;

	localparam int MAX_SIDE_DEF = 1024;
	localparam int RESET_SIDE   = 64;

	// Truncating division by 4, 6 or 9 as (sum * mul) >> DIV_SHIFT.
	// Exact for every sum below 2**SUM_W.
	localparam int MUL_W      = 22;
	localparam int DIV_SHIFT  = 23;
	localparam logic [MUL_W-1:0] DIV_MUL_4 = 22'd2097152;
	localparam logic [MUL_W-1:0] DIV_MUL_6 = 22'd1398102;
	localparam logic [MUL_W-1:0] DIV_MUL_9 = 22'd932068;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pix_t;

	// Which neighborhood size a result is averaged over.
	typedef enum logic [1:0] {
		DIV_4 = 2'd0,
		DIV_6 = 2'd1,
		DIV_9 = 2'd2
	} div_t;

	// Results one input can finish, in emission order: the pixel up-left of
	// it, the pixel above it, the pixel to its left and the pixel itself.
	typedef enum logic [1:0] {
		RES_UL   = 2'd0,
		RES_UP   = 2'd1,
		RES_LEFT = 2'd2,
		RES_HERE = 2'd3
	} res_t;

endpackage

`default_nettype wire

// File: rtl/box_blur_3x3_edge_normalized.sv
// Top level of the 3x3 box blur with edge-normalized means over an RGB stream.
`timescale 1ns / 1ps
`default_nettype none

// The first result of a pixel passes the stage 1, stage 2, stage 3 and output registers.
// One pixel per cycle while out_stall is low; a last-column pixel below the top row and a
// last-row pixel past the first column finish two results (four at the bottom-right corner),
// and the single result path takes one result per cycle, so extra results stall the input.
// Reset (arst_n low, asynchronous) empties the pipeline, zeroes the window and the position
// counters and sets the side to 64; the line memories are not cleared and need no pass.
module box_blur_3x3_edge_normalized import bb3_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_W-1:0]  image_side,
	// pixel input
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CH_W-1:0]   in_red,
	input  wire logic [CH_W-1:0]   in_green,
	input  wire logic [CH_W-1:0]   in_blue,
	// result output
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CH_W-1:0]        out_red,
	output logic [CH_W-1:0]        out_green,
	output logic [CH_W-1:0]        out_blue,
	output logic [POS_OUT_W-1:0]   out_row,
	output logic [POS_OUT_W-1:0]   out_col,
	output logic                   run_last,
	output logic                   frame_end
);

	localparam int POS_W  = $clog2(MAX_SIDE);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
	localparam int PROD_W = SUM_W + MUL_W;
	// The side kept is the clamped value minus one; a reset side above MAX_SIDE gives a side of 2.
	localparam logic [POS_W-1:0] RESET_LAST =
		POS_W'((RESET_SIDE > MAX_SIDE) ? 1 : RESET_SIDE - 1);

	// ------------------------------------------------------------------
	// Configuration. Writes must arrive only while the block is idle;
	// the block does not enforce this, and the port is always ready. A
	// write clamps the side into range and restarts the frame.
	// ------------------------------------------------------------------
	logic [POS_W-1:0] last_q;
	logic [CMP_W-1:0] side_ext;
	logic [CMP_W-1:0] side_clamp;
	logic             cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_comb begin
		side_ext = CMP_W'(image_side);
		if (side_ext < CMP_W'(2)) begin
			side_clamp = CMP_W'(2);
		end else if (side_ext > CMP_W'(MAX_SIDE)) begin
			side_clamp = CMP_W'(MAX_SIDE);
		end else begin
			side_clamp = side_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= RESET_LAST;
		end else if (cfg_fire) begin
			last_q <= POS_W'(side_clamp - CMP_W'(1));
		end
	end

	// ------------------------------------------------------------------
	// Handshake chain. Each stage takes a new entry when it is empty or
	// when its entry moves on in the same cycle.
	// ------------------------------------------------------------------
	logic s1_v_q;
	logic s1_adv;
	logic s1_ready;
	logic in_fire;
	logic s2_free;
	logic take;
	logic s3_v_q;
	logic s3_ready;
	logic out_v_q;
	logic out_ready;

	assign out_ready = !out_v_q || !out_stall;
	assign s3_ready  = !s3_v_q || out_ready;
	assign s1_adv    = s1_v_q && s2_free;
	assign s1_ready  = !s1_v_q || s1_adv;
	assign in_stall  = !s1_ready;
	assign in_fire   = in_valid && s1_ready;

	// ------------------------------------------------------------------
	// Raster position of the next pixel.
	// ------------------------------------------------------------------
	logic [POS_W-1:0] r_q;
	logic [POS_W-1:0] c_q;
	logic             last_col_now;
	logic             last_row_now;

	assign last_col_now = (c_q == last_q);
	assign last_row_now = (r_q == last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (cfg_fire) begin
			r_q <= '0;
			c_q <= '0;
		end else if (in_fire) begin
			if (last_col_now) begin
				c_q <= '0;
				r_q <= last_row_now ? '0 : r_q + POS_W'(1);
			end else begin
				c_q <= c_q + POS_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: pixel register and line memory reads. The two memories hold
	// the rows above and two above. A pixel rewrites its column as it
	// leaves the stage; consecutive pixels never share a column, so a read
	// never meets a pending write at the same address.
	// ------------------------------------------------------------------
	pix_t             mem_prev  [MAX_SIDE];
	pix_t             mem_prev2 [MAX_SIDE];
	pix_t             px_s1;
	pix_t             up1_s1;
	pix_t             up2_s1;
	logic [POS_W-1:0] r_s1;
	logic [POS_W-1:0] c_s1;
	logic             last_col_s1;
	logic             last_row_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			up1_s1 <= mem_prev[c_q];
			up2_s1 <= mem_prev2[c_q];
		end
		if (s1_adv) begin
			mem_prev[c_s1]  <= px_s1;
			mem_prev2[c_s1] <= up1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1       <= '{blue: in_blue, green: in_green, red: in_red};
			r_s1        <= r_q;
			c_s1        <= c_q;
			last_col_s1 <= last_col_now;
			last_row_s1 <= last_row_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_ready) begin
			s1_v_q <= in_fire;
		end
	end

	// Window of the two previous columns: entries 0..2 hold column C-1 and
	// entries 3..5 column C-2, each ordered two rows up, one row up, this row.
	pix_t win_q [6];
	pix_t col_new [3];

	assign col_new[0] = up2_s1;
	assign col_new[1] = up1_s1;
	assign col_new[2] = px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_fire) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			for (int i = 0; i < 3; i++) begin
				win_q[3+i] <= win_q[i];
				win_q[i]   <= col_new[i];
			end
		end
	end

	// Results this pixel finishes.
	logic [3:0] pend_s1;

	always_comb begin
		pend_s1           = '0;
		pend_s1[RES_UL]   = (r_s1 != '0) && (c_s1 != '0);
		pend_s1[RES_UP]   = (r_s1 != '0) && last_col_s1;
		pend_s1[RES_LEFT] = last_row_s1 && (c_s1 != '0);
		pend_s1[RES_HERE] = last_row_s1 && last_col_s1;
	end

	// ------------------------------------------------------------------
	// Stage 2: the full 3x3 stack of the pixel, and a mask of results still
	// owed. One result per cycle is summed for stage 3 while it is ready.
	// Stack index is [column][row], column 0 being C-2 and row 0 being R-2.
	// ------------------------------------------------------------------
	pix_t             stk_s2 [3][3];
	logic [3:0]       pend_s2;
	logic [POS_W-1:0] r_s2;
	logic [POS_W-1:0] c_s2;
	logic             r_ge2_s2;
	logic             c_ge2_s2;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int rr = 0; rr < 3; rr++) begin
				stk_s2[0][rr] <= win_q[3+rr];
				stk_s2[1][rr] <= win_q[rr];
				stk_s2[2][rr] <= col_new[rr];
			end
			r_s2     <= r_s1;
			c_s2     <= c_s1;
			r_ge2_s2 <= (r_s1 > POS_W'(1));
			c_ge2_s2 <= (c_s1 > POS_W'(1));
		end
	end

	res_t       sel;
	logic [3:0] pend_after;

	always_comb begin
		priority if (pend_s2[RES_UL]) begin
			sel = RES_UL;
		end else if (pend_s2[RES_UP]) begin
			sel = RES_UP;
		end else if (pend_s2[RES_LEFT]) begin
			sel = RES_LEFT;
		end else begin
			sel = RES_HERE;
		end
		pend_after      = pend_s2;
		pend_after[sel] = 1'b0;
	end

	assign take    = (pend_s2 != '0) && s3_ready;
	assign s2_free = (pend_s2 == '0) || (take && (pend_after == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (s1_adv) begin
			pend_s2 <= pend_s1;
		end else if (take) begin
			pend_s2 <= pend_after;
		end
	end

	// Column C-2 and row R-2 drop out at the left and top image borders,
	// and the right and bottom neighbors never exist for the results that
	// are finished late, so the in-image part is always columns 1..2 and
	// rows 1..2 plus, where present, column 0 and row 0.
	logic [2:0]       col_inc;
	logic [2:0]       row_inc;
	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;
	div_t             div_sel;
	logic [POS_W-1:0] row_sel;
	logic [POS_W-1:0] col_sel;

	always_comb begin
		col_inc    = 3'b110;
		row_inc    = 3'b110;
		col_inc[0] = c_ge2_s2 && ((sel == RES_UL) || (sel == RES_LEFT));
		row_inc[0] = r_ge2_s2 && ((sel == RES_UL) || (sel == RES_UP));
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int cc = 0; cc < 3; cc++) begin
			for (int rr = 0; rr < 3; rr++) begin
				if (col_inc[cc] && row_inc[rr]) begin
					sum_r = sum_r + SUM_W'(stk_s2[cc][rr].red);
					sum_g = sum_g + SUM_W'(stk_s2[cc][rr].green);
					sum_b = sum_b + SUM_W'(stk_s2[cc][rr].blue);
				end
			end
		end
		if (col_inc[0] && row_inc[0]) begin
			div_sel = DIV_9;
		end else if (col_inc[0] || row_inc[0]) begin
			div_sel = DIV_6;
		end else begin
			div_sel = DIV_4;
		end
		row_sel = ((sel == RES_UL) || (sel == RES_UP)) ? r_s2 - POS_W'(1) : r_s2;
		col_sel = ((sel == RES_UL) || (sel == RES_LEFT)) ? c_s2 - POS_W'(1) : c_s2;
	end

	// ------------------------------------------------------------------
	// Stage 3: sums of one result, then division by reciprocal multiply.
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] sum_r_s3;
	logic [SUM_W-1:0] sum_g_s3;
	logic [SUM_W-1:0] sum_b_s3;
	div_t             div_s3;
	logic [POS_W-1:0] row_s3;
	logic [POS_W-1:0] col_s3;
	logic             run_last_s3;
	logic             frame_end_s3;

	always_ff @(posedge clk) begin
		if (take) begin
			sum_r_s3     <= sum_r;
			sum_g_s3     <= sum_g;
			sum_b_s3     <= sum_b;
			div_s3       <= div_sel;
			row_s3       <= row_sel;
			col_s3       <= col_sel;
			run_last_s3  <= (pend_after == '0);
			frame_end_s3 <= (sel == RES_HERE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q <= 1'b0;
		end else if (s3_ready) begin
			s3_v_q <= take;
		end
	end

	logic [MUL_W-1:0]  mul_k;
	logic [PROD_W-1:0] prod_r;
	logic [PROD_W-1:0] prod_g;
	logic [PROD_W-1:0] prod_b;

	always_comb begin
		unique case (div_s3)
			DIV_9:   mul_k = DIV_MUL_9;
			DIV_6:   mul_k = DIV_MUL_6;
			DIV_4:   mul_k = DIV_MUL_4;
			default: mul_k = DIV_MUL_4;
		endcase
		prod_r = PROD_W'(sum_r_s3) * PROD_W'(mul_k);
		prod_g = PROD_W'(sum_g_s3) * PROD_W'(mul_k);
		prod_b = PROD_W'(sum_b_s3) * PROD_W'(mul_k);
	end

	// ------------------------------------------------------------------
	// Output register. It holds a result while the consumer stalls, and
	// the stages behind it keep working until they too are full.
	// ------------------------------------------------------------------
	logic [CH_W-1:0]      out_red_q;
	logic [CH_W-1:0]      out_green_q;
	logic [CH_W-1:0]      out_blue_q;
	logic [POS_OUT_W-1:0] out_row_q;
	logic [POS_OUT_W-1:0] out_col_q;
	logic                 run_last_q;
	logic                 frame_end_q;

	always_ff @(posedge clk) begin
		if (s3_v_q && out_ready) begin
			out_red_q   <= prod_r[DIV_SHIFT +: CH_W];
			out_green_q <= prod_g[DIV_SHIFT +: CH_W];
			out_blue_q  <= prod_b[DIV_SHIFT +: CH_W];
			out_row_q   <= POS_OUT_W'(row_s3);
			out_col_q   <= POS_OUT_W'(col_s3);
			run_last_q  <= run_last_s3;
			frame_end_q <= frame_end_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_ready) begin
			out_v_q <= s3_v_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// The position counters never pass the last column or row.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(c_q <= last_q) && (r_q <= last_q))
		else $error("position counter beyond image side");

	// A pixel that finishes the corner result finishes all four.
	a_corner_set: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && pend_s1[RES_HERE]) |-> (pend_s1 == '1))
		else $error("corner result without its companions");

	// The corner result is always the last one its pixel owes.
	a_corner_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (sel == RES_HERE)) |-> (pend_after == '0))
		else $error("results pending after the corner result");

	// A frame-end result closes the run of its pixel.
	a_frame_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> run_last)
		else $error("frame end without run end");

	// A new stack never overwrites results still owed.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (pend_s2 != '0)) |-> (take && (pend_after == '0)))
		else $error("pending results overwritten");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the 3x3 edge-normalized box blur over an RGB pixel stream.
`timescale 1ns / 1ps

module testbench;
	import bb3_pkg::*;

	// Cycles with no transfer on any channel before the run is declared hung. A correct run
	// never goes quiet except for a sender gap, a receiver stall burst, the pipeline latency
	// and the pause before a side write.
	localparam int QUIET_LIMIT = 2000;
	// Pause after the last expected result before a side write. Row-0 pixels finish no
	// result, so the block may still hold one in flight.
	localparam int HOLDOFF = 8;
	// Cycles watched after the last expected result for anything extra.
	localparam int TAIL = 12;

	// One row of the opening table: either a side write or a pixel transfer. Rows with
	// typed set carry the means that every result of that pixel must show.
	typedef enum bit {
		DO_SIDE,
		DO_PIXEL
	} step_kind_t;

	typedef struct packed {
		step_kind_t       kind;
		logic [CFG_W-1:0] side;
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  b;
		bit               typed;
		logic [CH_W-1:0]  er;
		logic [CH_W-1:0]  eg;
		logic [CH_W-1:0]  eb;
	} step_t;

	typedef struct packed {
		logic [CH_W-1:0]      red;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      blue;
		logic [POS_OUT_W-1:0] row;
		logic [POS_OUT_W-1:0] col;
		logic                 run_last;
		logic                 frame_end;
	} blur_out_t;

	// Side writes of 0 and 1 are raised to 2. In a 2x2 image the last pixel finishes all
	// four results, and each covers the whole image, so the means are known in advance:
	// all-ones stays all-ones, and the second image checks truncation (5/4, 3/4, and
	// 262139/4). The 3x3 frame mixes interior, edge and corner divisors, then the frame
	// wraps and a partial second frame is cut short by the next side write.
	localparam int OPENING_LEN = 25;
	localparam step_t OPENING [OPENING_LEN] = '{
		'{DO_SIDE,  11'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{DO_SIDE,  11'd1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h0001, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h0001, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h0001, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h0002, 16'h0003, 16'hFFFE, 1'b1, 16'h0001, 16'h0000, 16'hFFFE},
		'{DO_SIDE,  11'd3, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'h0000, 16'h8000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h5555, 16'hAAAA, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h0001, 16'h8001, 16'h1234, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFE, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h0000, 16'hFFFF, 16'h0001, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h1111, 16'h2222, 16'h3333, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'h4321, 16'h8765, 16'hCBA9, 1'b0, 16'h0000, 16'h0000, 16'h0000},
		'{DO_PIXEL, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     image_side = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CH_W-1:0]      in_red = '0;
	logic [CH_W-1:0]      in_green = '0;
	logic [CH_W-1:0]      in_blue = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CH_W-1:0]      out_red;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_blue;
	logic [POS_OUT_W-1:0] out_row;
	logic [POS_OUT_W-1:0] out_col;
	logic                 run_last;
	logic                 frame_end;

	box_blur_3x3_edge_normalized dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.image_side (image_side),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_row    (out_row),
		.out_col    (out_col),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

	// Shadow of the block: the two rows above, the two previous column stacks (rows R-2,
	// R-1, R), the side in force and the position of the next pixel.
	pix_t        row_above [MAX_SIDE_DEF];
	pix_t        row_above2 [MAX_SIDE_DEF];
	pix_t        stack_c1 [3];
	pix_t        stack_c2 [3];
	pix_t        nbhd [3][3];
	int unsigned side_now = RESET_SIDE;
	int unsigned row_at = 0;
	int unsigned col_at = 0;

	// Means still to arrive, oldest first.
	blur_out_t   due_means [$];

	int          fail_count = 0;
	int          quiet_cycles = 0;
	// Cleared for stretches of the run in which neither side idles.
	bit          idle_on = 1'b1;

	initial begin
		forever #6 clk = ~clk;
	end

	// Truncated mean over the columns c_lo..2 and rows r_lo..2 of the current
	// neighborhood (column 2 is the arriving column, row 2 the arriving row).
	function automatic blur_out_t area_mean(input int c_lo, input int r_lo,
			input int unsigned row, input int unsigned col, input bit corner);
		int unsigned sum_r;
		int unsigned sum_g;
		int unsigned sum_b;
		int unsigned n;
		blur_out_t   m;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		for (int c = c_lo; c < 3; c++) begin
			for (int r = r_lo; r < 3; r++) begin
				sum_r += nbhd[c][r].red;
				sum_g += nbhd[c][r].green;
				sum_b += nbhd[c][r].blue;
			end
		end
		n = (3 - c_lo) * (3 - r_lo);
		m.red = CH_W'(sum_r / n);
		m.green = CH_W'(sum_g / n);
		m.blue = CH_W'(sum_b / n);
		m.row = POS_OUT_W'(row);
		m.col = POS_OUT_W'(col);
		m.run_last = 1'b0;
		m.frame_end = corner;
		return m;
	endfunction

	// Works out the results a newly transferred pixel finishes, queues them and moves
	// the shadow state on by one pixel.
	task automatic track_pixel(input pix_t p, input bit typed, input pix_t typed_mean);
		blur_out_t   burst [4];
		int          k;
		int unsigned r;
		int unsigned c;
		bit          last_c;
		bit          last_r;
		r = row_at;
		c = col_at;
		k = 0;
		last_c = (c == side_now - 1);
		last_r = (r == side_now - 1);
		for (int i = 0; i < 3; i++) begin
			nbhd[0][i] = stack_c2[i];
			nbhd[1][i] = stack_c1[i];
		end
		nbhd[2][0] = row_above2[c];
		nbhd[2][1] = row_above[c];
		nbhd[2][2] = p;
		// Emission order: up-left, above (last column), left (last row), the pixel itself
		// (bottom-right corner). Only in-image rows and columns enter each mean.
		if (r >= 1 && c >= 1) begin
			burst[k] = area_mean((c >= 2) ? 0 : 1, (r >= 2) ? 0 : 1, r - 1, c - 1, 1'b0);
			k++;
		end
		if (r >= 1 && last_c) begin
			burst[k] = area_mean(1, (r >= 2) ? 0 : 1, r - 1, c, 1'b0);
			k++;
		end
		if (last_r && c >= 1) begin
			burst[k] = area_mean((c >= 2) ? 0 : 1, 1, r, c - 1, 1'b0);
			k++;
		end
		if (last_r && last_c) begin
			burst[k] = area_mean(1, 1, r, c, 1'b1);
			k++;
		end
		for (int j = 0; j < k; j++) begin
			if (typed) begin
				burst[j].red = typed_mean.red;
				burst[j].green = typed_mean.green;
				burst[j].blue = typed_mean.blue;
			end
			burst[j].run_last = (j == k - 1);
			due_means.push_back(burst[j]);
		end
		for (int i = 0; i < 3; i++) begin
			stack_c2[i] = stack_c1[i];
			stack_c1[i] = nbhd[2][i];
		end
		row_above2[c] = row_above[c];
		row_above[c] = p;
		// The bottom-right pixel wraps the position to the top-left of a new frame.
		if (last_c) begin
			col_at = 0;
			row_at = last_r ? 0 : r + 1;
		end else begin
			col_at = c + 1;
		end
	endtask

	// Offers one pixel, maybe after a short gap, and holds it until its transfer.
	task automatic push_pixel(input pix_t p, input bit typed, input pix_t typed_mean);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_red <= p.red;
		in_green <= p.green;
		in_blue <= p.blue;
		do @(posedge clk); while (in_stall !== 1'b0);
		track_pixel(p, typed, typed_mean);
	endtask

	// Stops offering pixels and waits until the block has nothing left in flight.
	task automatic settle();
		in_valid <= 1'b0;
		while (due_means.size() != 0) @(posedge clk);
		repeat (HOLDOFF) @(posedge clk);
	endtask

	// Writes the side register. The block clamps it to 2..MAX_SIDE and restarts the
	// frame with an empty window.
	task automatic write_side(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		image_side <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		side_now = (v < 2) ? 2 : ((v > MAX_SIDE_DEF) ? MAX_SIDE_DEF : v);
		for (int i = 0; i < 3; i++) begin
			stack_c1[i] = '0;
			stack_c2[i] = '0;
		end
		row_at = 0;
		col_at = 0;
	endtask

	// Random channels, with zero and full scale given extra weight.
	function automatic pix_t noisy_pixel();
		pix_t p;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 7))
				0: p[i*CH_W +: CH_W] = '0;
				1: p[i*CH_W +: CH_W] = '1;
				default: p[i*CH_W +: CH_W] = CH_W'($urandom);
			endcase
		end
		return p;
	endfunction

	// Receiver: random stall bursts while idling is on.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [CH_W-1:0] want,
			input logic [CH_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// Every result transfer is matched against the oldest expected result.
	always @(posedge clk) begin : result_check
		blur_out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (due_means.size() == 0) begin
				fail_count++;
				$error("unexpected result at row %0d col %0d", out_row, out_col);
			end else begin
				want = due_means.pop_front();
				check_field("out_red", want.red, out_red);
				check_field("out_green", want.green, out_green);
				check_field("out_blue", want.blue, out_blue);
				check_field("out_row", CH_W'(want.row), CH_W'(out_row));
				check_field("out_col", CH_W'(want.col), CH_W'(out_col));
				check_field("run_last", CH_W'(want.run_last), CH_W'(run_last));
				check_field("frame_end", CH_W'(want.frame_end), CH_W'(frame_end));
			end
		end
	end

	// Watchdog: a stretch with no transfer on any channel means the block is hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
				|| (cfg_valid && cfg_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int          random_items;
		int unsigned eff;
		int unsigned count;
		logic [CFG_W-1:0] side;
		step_t       s;
		for (int i = 0; i < MAX_SIDE_DEF; i++) begin
			row_above[i] = '0;
			row_above2[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			stack_c1[i] = '0;
			stack_c2[i] = '0;
		end
		random_items = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The side out of reset is 64: one full row and three pixels of the second
		// finish the first two results of the top row.
		repeat (RESET_SIDE + 3) push_pixel(noisy_pixel(), 1'b0, '0);

		for (int i = 0; i < OPENING_LEN; i++) begin
			s = OPENING[i];
			if (s.kind == DO_SIDE) begin
				settle();
				write_side(s.side);
			end else begin
				push_pixel('{blue: s.b, green: s.g, red: s.r}, s.typed,
					'{blue: s.eb, green: s.eg, red: s.er});
			end
		end

		// Random phases: mostly small images sent as whole frames (wrapping into the next
		// frame), some cut short by the next side write, a few with sides below the floor.
		while (random_items < 40) begin
			idle_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: side = CFG_W'($urandom_range(0, 1));
				default: side = CFG_W'($urandom_range(2, 5));
			endcase
			settle();
			write_side(side);
			eff = side_now;
			if ($urandom_range(0, 3) == 0)
				count = $urandom_range(1, eff * eff - 1);
			else
				count = eff * eff * $urandom_range(1, 2);
			if (random_items + count > 60)
				count = 60 - random_items;
			repeat (count) push_pixel(noisy_pixel(), 1'b0, '0);
			random_items += count;
		end

		// Closing stretch at full rate on both sides.
		idle_on = 1'b0;
		settle();
		write_side(CFG_W'(4));
		repeat (16) push_pixel(noisy_pixel(), 1'b0, '0);

		in_valid <= 1'b0;
		while (due_means.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
